// ===== design/envelope_sine_voice_with_choke_assert.svh =====
// Assertion macros for the sine voice top level.
// Depends on clk and rst_n being visible where they are used.
`ifndef ENVELOPE_SINE_VOICE_WITH_CHOKE_ASSERT_SVH
`define ENVELOPE_SINE_VOICE_WITH_CHOKE_ASSERT_SVH

// Plain clocked property, disabled in reset.
`define ESV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication, disabled in reset.
`define ESV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/esv_pkg.sv =====
// Shared types, codes and the sine ROM contents for the sine voice.
// No dependencies.
`timescale 1ns / 1ps

package esv_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SINE_DEPTH  = 1024;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int SIN_AW      = $clog2(SINE_DEPTH);

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    localparam logic [2:0] CFG_INDEX_STEP   = 3'd0;
    localparam logic [2:0] CFG_TABLE_LENGTH = 3'd1;
    localparam logic [2:0] CFG_PHASE_PER_HZ = 3'd2;
    localparam logic [2:0] CFG_CHOKE_LENGTH = 3'd3;
    localparam logic [2:0] CFG_IDLE_THRESH  = 3'd4;
    localparam logic [2:0] CFG_TABLES_VALID = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PLAY  = 2'd1,
        MODE_CHOKE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_NOTE_ON   = 2'd1,
        REQ_WR_AMP    = 2'd2,
        REQ_WR_PITCH  = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_WRITE,
        CMD_ADDR_LO,
        CMD_ADDR_HI,
        CMD_MUL_A0,
        CMD_MUL_A1,
        CMD_MUL_P0,
        CMD_MUL_P1,
        CMD_PITCH,
        CMD_CAPTURE,
        CMD_START,
        CMD_MUL_C,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_END,
        CMD_SINE_RD,
        CMD_MUL_S,
        CMD_MUL_F,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        req_t  req;
        mode_t mode;
        logic  clamp;
        logic  div_last;
        logic  out_free;
    } stat_t;

    typedef struct packed {
        logic [31:0] index_step;
        logic [10:0] table_length;
        logic [31:0] phase_per_hz;
        logic [15:0] choke_length;
        logic [15:0] idle_threshold;
        logic        tables_valid;
    } cfg_t;

    typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

    function automatic logic signed [15:0] sine_entry(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        longint      s;
        logic        neg;
        x = (k * TWO_PI_Q30) / SINE_DEPTH;
        neg = 1'b0;
        if (x >= PI_Q30)
        begin
            x = x - PI_Q30;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q30)
            x = PI_Q30 - x;
        x2 = (x * x) >> 30;
        t = x;
        s = longint'(x);
        t = ((t * x2) >> 30) / 6;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 20;
        s = s + longint'(t);
        t = ((t * x2) >> 30) / 42;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 72;
        s = s + longint'(t);
        t = ((t * x2) >> 30) / 110;
        s = s - longint'(t);
        if (s < 0)
            s = 0;
        v = (64'(s) + 64'd16384) >> 15;
        if (v > 64'd32767)
            v = 64'd32767;
        return neg ? -16'(v) : 16'(v);
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        for (int k = 0; k < SINE_DEPTH; k++)
            rom[k] = sine_entry(64'(k));
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// ===== design/esv_dpath.sv =====
// Datapath of the sine voice: envelope tables, sine ROM, shared multiplier,
// serial divider and voice state. Depends on esv_pkg.
`timescale 1ns / 1ps

module esv_dpath
(
    input  logic               clk,
    input  logic               rst_n,
    input  esv_pkg::cmd_t      cmd,
    input  esv_pkg::cfg_t      cfg,
    input  logic               in_load,
    input  esv_pkg::req_t      in_req,
    input  logic [9:0]         in_index,
    input  logic [15:0]        in_value,
    output esv_pkg::stat_t     stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [15:0]        out_sample,
    output logic [1:0]         out_mode
);

    localparam int AW = esv_pkg::TAB_AW;
    localparam int SW = esv_pkg::SIN_AW;

    logic [15:0] amp_mem   [esv_pkg::TABLE_DEPTH];
    logic [15:0] pitch_mem [esv_pkg::TABLE_DEPTH];

    esv_pkg::req_t  req_reg;
    logic [9:0]     idx_reg;
    logic [15:0]    val_reg;

    esv_pkg::mode_t mode_reg, mode_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic        seen_reg, seen_next;
    logic [15:0] fade_reg, fade_next;
    logic [15:0] cap_amp_reg, cap_amp_next;
    logic [15:0] cap_pitch_reg, cap_pitch_next;

    logic [15:0] amp_rd_reg, pitch_rd_reg;
    logic [15:0] lo_amp_reg, lo_pitch_reg;
    logic [15:0] amp_reg, amp_next;
    logic [15:0] pitch_reg, pitch_next;
    logic [63:0] prod_reg;
    logic [33:0] acc_reg;
    logic signed [15:0] sine_reg;
    logic [15:0] samp_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    esv_pkg::mode_t out_mode_reg;

    logic [AW:0]   len_eff;
    logic [AW-1:0] last_ent;
    logic [15:0]   pos_i;
    logic [15:0]   frac;
    logic [16:0]   inv_frac;
    logic          clamp;
    logic [AW-1:0] addr_lo, addr_hi, rd_addr, wr_addr;
    logic          wr_ok;
    logic [33:0]   isum;
    logic [15:0]   interp;
    logic [15:0]   choke_len;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_out;
    logic [15:0]   sine_mag;
    logic [32:0]   rsum;
    logic [15:0]   rnd;
    logic [16:0]   rem_sh;
    logic          div_ge;
    logic [31:0]   step;
    logic [32:0]   psum;
    logic [15:0]   pitch_sel;
    logic [15:0]   fade_inc;

    // Clamp the table length to one through the table depth.
    always_comb
    begin
        if (cfg.table_length == 11'd0)
            len_eff = (AW+1)'(1);
        else if (32'(cfg.table_length) > esv_pkg::TABLE_DEPTH)
            len_eff = (AW+1)'(esv_pkg::TABLE_DEPTH);
        else
            len_eff = (AW+1)'(cfg.table_length);
    end

    assign last_ent  = AW'(len_eff - (AW+1)'(1));
    assign pos_i     = pos_reg[31:16];
    assign frac      = pos_reg[15:0];
    assign inv_frac  = 17'h10000 - 17'(frac);
    assign clamp     = 17'(pos_i) >= 17'(last_ent);
    assign addr_lo   = clamp ? last_ent : AW'(pos_i);
    assign addr_hi   = addr_lo + AW'(1);
    assign rd_addr   = (cmd == esv_pkg::CMD_ADDR_HI) ? addr_hi : addr_lo;
    assign wr_addr   = AW'(idx_reg);
    assign wr_ok     = 32'(idx_reg) < esv_pkg::TABLE_DEPTH;
    assign isum      = acc_reg + prod_reg[33:0] + 34'd32768;
    assign interp    = isum[31:16];
    assign choke_len = (cfg.choke_length == 16'd0) ? 16'd1 : cfg.choke_length;
    assign sine_mag  = sine_reg[15] ? 16'(-sine_reg) : 16'(sine_reg);
    assign rsum      = 33'(prod_reg[31:0]) + 33'd32768;
    assign rnd       = rsum[31:16];
    assign rem_sh    = {rem_reg, quo_reg[31]};
    assign div_ge    = rem_sh >= 17'(choke_len);
    assign step      = prod_reg[43:12];
    assign psum      = 33'(pos_reg) + 33'(cfg.index_step);
    assign pitch_sel = (mode_reg == esv_pkg::MODE_CHOKE) ? cap_pitch_reg : pitch_reg;
    assign fade_inc  = fade_reg + 16'd1;

    // Shared multiplier operand select.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            esv_pkg::CMD_MUL_A0:
            begin
                mul_a = 32'(lo_amp_reg);
                mul_b = 32'(inv_frac);
            end
            esv_pkg::CMD_MUL_A1:
            begin
                mul_a = 32'(amp_rd_reg);
                mul_b = 32'(frac);
            end
            esv_pkg::CMD_MUL_P0:
            begin
                mul_a = 32'(lo_pitch_reg);
                mul_b = 32'(inv_frac);
            end
            esv_pkg::CMD_MUL_P1:
            begin
                mul_a = 32'(pitch_rd_reg);
                mul_b = 32'(frac);
            end
            esv_pkg::CMD_MUL_S:
            begin
                mul_a = 32'(sine_mag);
                mul_b = 32'(amp_reg);
            end
            esv_pkg::CMD_MUL_F:
            begin
                mul_a = 32'(pitch_sel);
                mul_b = cfg.phase_per_hz;
            end
            esv_pkg::CMD_MUL_C:
            begin
                mul_a = 32'(cap_amp_reg);
                mul_b = 32'(choke_len - fade_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out = 64'(mul_a) * 64'(mul_b);

    // Voice state and lookup results.
    always_comb
    begin
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        fade_next      = fade_reg;
        cap_amp_next   = cap_amp_reg;
        cap_pitch_next = cap_pitch_reg;
        amp_next       = amp_reg;
        pitch_next     = pitch_reg;
        case (cmd)
            esv_pkg::CMD_MUL_P0:
                amp_next = !cfg.tables_valid ? 16'd0 : (clamp ? lo_amp_reg : interp);
            esv_pkg::CMD_PITCH:
                pitch_next = !cfg.tables_valid ? 16'd0 : (clamp ? lo_pitch_reg : interp);
            esv_pkg::CMD_DIV_END:
                amp_next = (fade_reg < choke_len) ? quo_reg[15:0] : 16'd0;
            esv_pkg::CMD_CAPTURE:
            begin
                cap_amp_next   = amp_reg;
                cap_pitch_next = pitch_reg;
                fade_next      = 16'd0;
                mode_next      = esv_pkg::MODE_CHOKE;
            end
            esv_pkg::CMD_START:
            begin
                phase_next = '0;
                pos_next   = '0;
                seen_next  = 1'b0;
                mode_next  = esv_pkg::MODE_PLAY;
            end
            esv_pkg::CMD_FINISH:
            begin
                if (mode_reg == esv_pkg::MODE_PLAY)
                begin
                    phase_next = phase_reg + step;
                    pos_next   = psum[32] ? '1 : psum[31:0];
                    seen_next  = seen_reg | (amp_reg >= cfg.idle_threshold);
                    if (seen_next && (amp_reg < cfg.idle_threshold))
                        mode_next = esv_pkg::MODE_IDLE;
                end
                else if (mode_reg == esv_pkg::MODE_CHOKE)
                begin
                    fade_next = fade_inc;
                    if ((fade_inc >= choke_len) || (fade_inc == 16'd0))
                    begin
                        phase_next = '0;
                        pos_next   = '0;
                        seen_next  = 1'b0;
                        mode_next  = esv_pkg::MODE_PLAY;
                    end
                    else
                    begin
                        phase_next = phase_reg + step;
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= esv_pkg::MODE_IDLE;
            phase_reg     <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            fade_reg      <= '0;
            cap_amp_reg   <= '0;
            cap_pitch_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            fade_reg      <= fade_next;
            cap_amp_reg   <= cap_amp_next;
            cap_pitch_reg <= cap_pitch_next;
            if (cmd == esv_pkg::CMD_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, tables and ROM.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            req_reg <= in_req;
            idx_reg <= in_index;
            val_reg <= in_value;
        end
        if ((cmd == esv_pkg::CMD_WRITE) && wr_ok)
        begin
            if (req_reg == esv_pkg::REQ_WR_AMP)
                amp_mem[wr_addr] <= val_reg;
            else if (req_reg == esv_pkg::REQ_WR_PITCH)
                pitch_mem[wr_addr] <= val_reg;
        end
        if ((cmd == esv_pkg::CMD_ADDR_LO) || (cmd == esv_pkg::CMD_ADDR_HI))
        begin
            amp_rd_reg   <= amp_mem[rd_addr];
            pitch_rd_reg <= pitch_mem[rd_addr];
        end
        if (cmd == esv_pkg::CMD_ADDR_HI)
        begin
            lo_amp_reg   <= amp_rd_reg;
            lo_pitch_reg <= pitch_rd_reg;
        end
        if (cmd == esv_pkg::CMD_SINE_RD)
            sine_reg <= esv_pkg::SINE_ROM[phase_reg[31 -: SW]];
        // Hold the product across idle steps so the phase step survives a stall.
        if (cmd inside {esv_pkg::CMD_MUL_A0, esv_pkg::CMD_MUL_A1, esv_pkg::CMD_MUL_P0,
                        esv_pkg::CMD_MUL_P1, esv_pkg::CMD_MUL_S, esv_pkg::CMD_MUL_F,
                        esv_pkg::CMD_MUL_C})
            prod_reg <= mul_out;
        if ((cmd == esv_pkg::CMD_MUL_A1) || (cmd == esv_pkg::CMD_MUL_P1))
            acc_reg <= prod_reg[33:0];
        amp_reg   <= amp_next;
        pitch_reg <= pitch_next;
        if (cmd == esv_pkg::CMD_MUL_F)
            samp_reg <= sine_reg[15] ? -rnd : rnd;
        if (cmd == esv_pkg::CMD_DIV_INIT)
        begin
            rem_reg <= '0;
            quo_reg <= prod_reg[31:0];
            cnt_reg <= '0;
        end
        else if (cmd == esv_pkg::CMD_DIV_STEP)
        begin
            rem_reg <= div_ge ? 16'(rem_sh - 17'(choke_len)) : rem_sh[15:0];
            quo_reg <= {quo_reg[30:0], div_ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd == esv_pkg::CMD_FINISH)
        begin
            out_sample_reg <= (mode_reg == esv_pkg::MODE_IDLE) ? 16'd0 : samp_reg;
            out_mode_reg   <= mode_next;
        end
    end

    assign stat.req      = req_reg;
    assign stat.mode     = mode_reg;
    assign stat.clamp    = clamp;
    assign stat.div_last = cnt_reg == 5'd31;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_mode   = out_mode_reg;

endmodule

// ===== design/esv_ctrl.sv =====
// Sequencer of the sine voice: steps the datapath through one request.
// Depends on esv_pkg.
`timescale 1ns / 1ps

module esv_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  esv_pkg::stat_t stat,
    output esv_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_WAIT, S_DISP, S_LA, S_LB, S_LC, S_LD, S_LE, S_LF, S_LG,
        S_CM, S_DI, S_DS, S_DE, S_SR, S_MS, S_MF, S_FW
    } state_t;

    state_t        state_reg;
    esv_pkg::cmd_t cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WAIT;
            cmd_reg   <= esv_pkg::CMD_NOP;
        end
        else
        begin
            case (state_reg)
                S_WAIT:
                begin
                    cmd_reg <= esv_pkg::CMD_NOP;
                    if (in_valid)
                        state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    case (stat.req)
                        esv_pkg::REQ_WR_AMP, esv_pkg::REQ_WR_PITCH:
                        begin
                            state_reg <= S_WAIT;
                            cmd_reg   <= esv_pkg::CMD_WRITE;
                        end
                        esv_pkg::REQ_NOTE_ON:
                        begin
                            if (stat.mode == esv_pkg::MODE_PLAY)
                            begin
                                state_reg <= S_LA;
                                cmd_reg   <= esv_pkg::CMD_ADDR_LO;
                            end
                            else if (stat.mode == esv_pkg::MODE_IDLE)
                            begin
                                state_reg <= S_WAIT;
                                cmd_reg   <= esv_pkg::CMD_START;
                            end
                            else
                            begin
                                state_reg <= S_WAIT;
                                cmd_reg   <= esv_pkg::CMD_NOP;
                            end
                        end
                        default:
                        begin
                            if (stat.mode == esv_pkg::MODE_PLAY)
                            begin
                                state_reg <= S_LA;
                                cmd_reg   <= esv_pkg::CMD_ADDR_LO;
                            end
                            else if (stat.mode == esv_pkg::MODE_CHOKE)
                            begin
                                state_reg <= S_CM;
                                cmd_reg   <= esv_pkg::CMD_MUL_C;
                            end
                            else
                            begin
                                state_reg <= S_FW;
                                cmd_reg   <= esv_pkg::CMD_NOP;
                            end
                        end
                    endcase
                end
                S_LA:
                begin
                    state_reg <= S_LB;
                    cmd_reg   <= esv_pkg::CMD_ADDR_HI;
                end
                S_LB:
                begin
                    state_reg <= S_LC;
                    cmd_reg   <= esv_pkg::CMD_MUL_A0;
                end
                S_LC:
                begin
                    state_reg <= S_LD;
                    cmd_reg   <= esv_pkg::CMD_MUL_A1;
                end
                S_LD:
                begin
                    state_reg <= S_LE;
                    cmd_reg   <= esv_pkg::CMD_MUL_P0;
                end
                S_LE:
                begin
                    state_reg <= S_LF;
                    cmd_reg   <= esv_pkg::CMD_MUL_P1;
                end
                S_LF:
                begin
                    state_reg <= S_LG;
                    cmd_reg   <= esv_pkg::CMD_PITCH;
                end
                S_LG:
                begin
                    if (stat.req == esv_pkg::REQ_NOTE_ON)
                    begin
                        state_reg <= S_WAIT;
                        cmd_reg   <= esv_pkg::CMD_CAPTURE;
                    end
                    else
                    begin
                        state_reg <= S_SR;
                        cmd_reg   <= esv_pkg::CMD_SINE_RD;
                    end
                end
                S_CM:
                begin
                    state_reg <= S_DI;
                    cmd_reg   <= esv_pkg::CMD_DIV_INIT;
                end
                S_DI:
                begin
                    state_reg <= S_DS;
                    cmd_reg   <= esv_pkg::CMD_DIV_STEP;
                end
                S_DS:
                begin
                    if (stat.div_last)
                    begin
                        state_reg <= S_DE;
                        cmd_reg   <= esv_pkg::CMD_DIV_END;
                    end
                    else
                    begin
                        cmd_reg <= esv_pkg::CMD_DIV_STEP;
                    end
                end
                S_DE:
                begin
                    state_reg <= S_SR;
                    cmd_reg   <= esv_pkg::CMD_SINE_RD;
                end
                S_SR:
                begin
                    state_reg <= S_MS;
                    cmd_reg   <= esv_pkg::CMD_MUL_S;
                end
                S_MS:
                begin
                    state_reg <= S_MF;
                    cmd_reg   <= esv_pkg::CMD_MUL_F;
                end
                S_MF:
                begin
                    state_reg <= S_FW;
                    cmd_reg   <= esv_pkg::CMD_NOP;
                end
                S_FW:
                begin
                    // hold until the result register can take the transfer
                    if (stat.out_free)
                    begin
                        state_reg <= S_WAIT;
                        cmd_reg   <= esv_pkg::CMD_FINISH;
                    end
                    else
                    begin
                        cmd_reg <= esv_pkg::CMD_NOP;
                    end
                end
                default:
                begin
                    state_reg <= S_WAIT;
                    cmd_reg   <= esv_pkg::CMD_NOP;
                end
            endcase
        end
    end

    assign in_ready = state_reg == S_WAIT;
    assign cmd      = cmd_reg;

endmodule

// ===== design/envelope_sine_voice_with_choke.sv =====
// One item at a time: the shared multiplier and the 32-step serial divider
// (used while choking) step through each item before the next is taken.
// The next item is taken while a result waits; a tick holds before finishing until it goes.
// Reset (rst_n low, async): voice idle, phase and position cleared, config registers at defaults;
// envelope tables are not cleared and must be loaded before use.
`timescale 1ns / 1ps

`include "envelope_sine_voice_with_choke_assert.svh"

module envelope_sine_voice_with_choke
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [9:0] table_index, [25:10] table_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] sample_out, [17:16] voice_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    esv_pkg::cfg_t  cfg_reg;
    esv_pkg::stat_t stat;
    esv_pkg::cmd_t  cmd;
    logic           in_load;
    logic [15:0]    out_sample;
    logic [1:0]     out_mode;

    // Register bank: always ready, a transfer writes the indexed register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.index_step     <= 32'd65536;
            cfg_reg.table_length   <= 11'd1024;
            cfg_reg.phase_per_hz   <= 32'd22906492;
            cfg_reg.choke_length   <= 16'd240;
            cfg_reg.idle_threshold <= 16'd66;
            cfg_reg.tables_valid   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                esv_pkg::CFG_INDEX_STEP:   cfg_reg.index_step     <= cfg_data;
                esv_pkg::CFG_TABLE_LENGTH: cfg_reg.table_length   <= cfg_data[10:0];
                esv_pkg::CFG_PHASE_PER_HZ: cfg_reg.phase_per_hz   <= cfg_data;
                esv_pkg::CFG_CHOKE_LENGTH: cfg_reg.choke_length   <= cfg_data[15:0];
                esv_pkg::CFG_IDLE_THRESH:  cfg_reg.idle_threshold <= cfg_data[15:0];
                esv_pkg::CFG_TABLES_VALID: cfg_reg.tables_valid   <= cfg_data[0];
                default:                   cfg_reg.tables_valid   <= cfg_reg.tables_valid;
            endcase
        end
    end

    // Input transfer latches the item into the datapath.
    assign in_load = s_axis_tvalid && s_axis_tready;

    esv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    esv_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .in_load    (in_load),
        .in_req     (esv_pkg::req_t'(s_axis_tuser)),
        .in_index   (s_axis_tdata[9:0]),
        .in_value   (s_axis_tdata[25:10]),
        .stat       (stat),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_sample (out_sample),
        .out_mode   (out_mode)
    );

    // Pad the result out to whole bytes.
    assign m_axis_tdata = {6'd0, out_mode, out_sample};

    // One item in flight: a transfer in drops ready on the next cycle.
    `ESV_ASSERT(a_single_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second item taken while busy")
    // A new result comes from a finishing step, which follows a busy cycle.
    `ESV_ASSERT_IMP(a_result_src, $rose(m_axis_tvalid), $past(!s_axis_tready, 2), "result appeared without a finishing step")

endmodule
